// ----- hw/rtl/ilp_pkg.sv -----
// types, constants and codes shared by the integer list parser
package ilp_pkg;

    // most numbers taken in one line, on top of the max_entries register
    localparam int ENTRY_LIMIT = 256;

    // result queue between the parser and the result channel
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // configuration register indexes
    localparam logic CFG_ENTRY_BYTES = 1'b0;
    localparam logic CFG_MAX_ENTRIES = 1'b1;

    // status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_ILLEGAL     = 3'd1;
    localparam logic [2:0] ST_TOO_MANY    = 3'd2;
    localparam logic [2:0] ST_OUT_OF_RNG  = 3'd3;
    localparam logic [2:0] ST_SEP_EXPECT  = 3'd4;

    // result kinds
    localparam logic KIND_VALUE   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // characters
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_X     = 8'h78;
    localparam logic [7:0] CHAR_PCT   = 8'h25;
    localparam logic [7:0] CHAR_COMMA = 8'h2c;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LF    = 8'h66;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;

    typedef struct packed {
        logic [7:0] character;
        logic       line_end;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] number;
        logic [8:0]  position;
        logic [2:0]  status;
        logic        last;
    } out_item_t;

    // digit value of a character, 16 when it is no hex digit
    function automatic logic [4:0] digit_value(input logic [7:0] c);
        logic [4:0] d;
        d = 5'd16;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d = 5'(c - CHAR_ZERO);
        end else if (c >= CHAR_LA && c <= CHAR_LF) begin
            d = 5'(c - CHAR_LA) + 5'd10;
        end else if (c >= CHAR_UA && c <= CHAR_UF) begin
            d = 5'(c - CHAR_UA) + 5'd10;
        end
        return d;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_TAB);
    endfunction

endpackage

// ----- hw/rtl/integer_list_parser_unit.sv -----
// integer list parser: one character per request in, values and line summaries out
//
// usage:
//   s_* channel takes one request per cycle: an ascii character or a line end
//   m_* channel delivers results: one per parsed number (kind 0, with its index)
//   and one summary per line end (kind 1, count and status, last set)
//   cfg_we/cfg_index/cfg_wdata write entry_bytes (0) and max_entries (1) while idle
// latency and throughput:
//   a request is parsed in the cycle it is accepted; its results sit in a
//   4-entry result queue and can leave at the next cycle, one per cycle
//   one request per cycle is sustained; a line end may queue two results
// stalls:
//   s_ready drops while the queue has less than two free slots, so a stalled
//   receiver holds the parser once three results are waiting; requests that
//   raise no result keep flowing until then
// reset:
//   aresetn low empties the queue, returns the parser to the start of a line
//   and sets entry_bytes to 1 and max_entries to 256
module integer_list_parser_unit
    import ilp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_data,

    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data,

    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [8:0] cfg_wdata
);

    // parse modes
    localparam logic [2:0] MODE_START = 3'd0;
    localparam logic [2:0] MODE_ZERO  = 3'd1;
    localparam logic [2:0] MODE_DEC   = 3'd2;
    localparam logic [2:0] MODE_HEX   = 3'd3;
    localparam logic [2:0] MODE_BIN   = 3'd4;
    localparam logic [2:0] MODE_AFTER = 3'd5;

    // configuration registers
    logic [2:0]  entry_bytes_reg;
    logic [8:0]  max_entries_reg;

    // line state
    logic [2:0]  mode_reg,  mode_next;
    logic [31:0] acc_reg,   acc_next;
    logic [8:0]  count_reg, count_next;
    logic [2:0]  err_reg,   err_next;

    // result queue
    out_item_t        fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;

    logic       s_accept;
    logic       m_accept;
    logic [1:0] push_num;
    out_item_t  res0, res1;

    // closing the pending number
    logic       too_many;
    logic       out_of_range;
    logic [2:0] close_err;
    out_item_t  value_res;

    // character decode
    logic [7:0]  ch;
    logic [4:0]  digit;
    logic        digit_ok;
    logic [31:0] acc_grown;
    logic        num_mode;
    logic        closing;
    logic [8:0]  sum_pos;
    logic [2:0]  sum_status;

    assign s_ready  = (fill_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign s_accept = s_valid && s_ready;
    assign m_valid  = (fill_reg != '0);
    assign m_accept = m_valid && m_ready;
    assign m_data   = fifo_mem[rd_ptr_reg];

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_bytes_reg <= 3'd1;
            max_entries_reg <= 9'd256;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ENTRY_BYTES: entry_bytes_reg <= cfg_wdata[2:0];
                CFG_MAX_ENTRIES: max_entries_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // checks for the number held in the accumulator
    always_comb begin
        too_many = (count_reg >= max_entries_reg) || (32'(count_reg) >= ENTRY_LIMIT);
        case (entry_bytes_reg)
            3'd0:    out_of_range = (acc_reg != '0);
            3'd1:    out_of_range = (acc_reg[31:8] != '0);
            3'd2:    out_of_range = (acc_reg[31:16] != '0);
            3'd3:    out_of_range = (acc_reg[31:24] != '0);
            default: out_of_range = 1'b0;
        endcase
        if (too_many) begin
            close_err = ST_TOO_MANY;
        end else if (out_of_range) begin
            close_err = ST_OUT_OF_RNG;
        end else begin
            close_err = ST_OK;
        end
        value_res.kind     = KIND_VALUE;
        value_res.number   = acc_reg;
        value_res.position = count_reg;
        value_res.status   = ST_OK;
        value_res.last     = 1'b0;
    end

    // digit accumulation per radix
    always_comb begin
        ch    = s_data.character;
        digit = digit_value(ch);
        case (mode_reg)
            MODE_HEX: begin
                digit_ok  = 1'b1;
                acc_grown = {acc_reg[27:0], 4'b0} + 32'(digit);
            end
            MODE_BIN: begin
                digit_ok  = (digit < 5'd2);
                acc_grown = {acc_reg[30:0], 1'b0} + 32'(digit);
            end
            default: begin
                digit_ok  = (digit < 5'd10);
                acc_grown = {acc_reg[28:0], 3'b0} + {acc_reg[30:0], 1'b0} + 32'(digit);
            end
        endcase
        if (mode_reg == MODE_HEX) begin
            digit_ok = (digit < 5'd16);
        end
    end

    // parser step
    always_comb begin
        mode_next  = mode_reg;
        acc_next   = acc_reg;
        count_next = count_reg;
        err_next   = err_reg;
        push_num   = 2'd0;
        res0       = value_res;
        res1       = value_res;
        num_mode   = (mode_reg >= MODE_ZERO) && (mode_reg <= MODE_BIN);
        closing    = 1'b0;
        sum_pos    = count_reg;
        sum_status = err_reg;

        if (s_accept) begin
            if (s_data.line_end) begin
                closing = (err_reg == ST_OK) && num_mode;
                if (closing && close_err == ST_OK) begin
                    sum_pos = count_reg + 9'd1;
                end else if (closing) begin
                    sum_status = close_err;
                end
                // summary follows the value result of a pending number, if any
                if (closing && close_err == ST_OK) begin
                    push_num = 2'd2;
                    res1.kind     = KIND_SUMMARY;
                    res1.number   = '0;
                    res1.position = sum_pos;
                    res1.status   = sum_status;
                    res1.last     = 1'b1;
                end else begin
                    push_num = 2'd1;
                    res0.kind     = KIND_SUMMARY;
                    res0.number   = '0;
                    res0.position = sum_pos;
                    res0.status   = sum_status;
                    res0.last     = 1'b1;
                end
                mode_next  = MODE_START;
                acc_next   = '0;
                count_next = '0;
                err_next   = ST_OK;
            end else if (err_reg == ST_OK) begin
                if (mode_reg == MODE_START) begin
                    if (!is_blank(ch)) begin
                        acc_next = '0;
                        if (ch == CHAR_ZERO) begin
                            mode_next = MODE_ZERO;
                        end else if (ch == CHAR_PCT) begin
                            mode_next = MODE_BIN;
                        end else if (ch >= CHAR_ONE && ch <= CHAR_NINE) begin
                            acc_next  = 32'(digit);
                            mode_next = MODE_DEC;
                        end else begin
                            err_next = ST_ILLEGAL;
                        end
                    end
                end else if (mode_reg == MODE_ZERO && ch == CHAR_X) begin
                    mode_next = MODE_HEX;
                end else if (num_mode && digit_ok) begin
                    acc_next = acc_grown;
                    if (mode_reg == MODE_ZERO) begin
                        mode_next = MODE_DEC;
                    end
                end else if (num_mode && close_err != ST_OK) begin
                    err_next = close_err;
                end else begin
                    // number ends here (if one was open), then expect a separator
                    if (num_mode) begin
                        push_num   = 2'd1;
                        count_next = count_reg + 9'd1;
                        acc_next   = '0;
                    end
                    if (is_blank(ch)) begin
                        mode_next = MODE_AFTER;
                    end else if (ch == CHAR_COMMA) begin
                        mode_next = MODE_START;
                    end else begin
                        mode_next = MODE_AFTER;
                        err_next  = ST_SEP_EXPECT;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_START;
            acc_reg   <= '0;
            count_reg <= '0;
            err_reg   <= ST_OK;
        end else begin
            mode_reg  <= mode_next;
            acc_reg   <= acc_next;
            count_reg <= count_next;
            err_reg   <= err_next;
        end
    end

    // result queue storage
    always_ff @(posedge aclk) begin
        if (push_num != 2'd0) begin
            fifo_mem[wr_ptr_reg] <= res0;
        end
        if (push_num == 2'd2) begin
            fifo_mem[wr_ptr_reg + PTR_W'(1)] <= res1;
        end
    end

    // result queue pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_num);
            if (m_accept) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            fill_reg <= fill_reg + CNT_W'(push_num) - CNT_W'(m_accept);
        end
    end

endmodule

// ----- verif/ilp_checker.sv -----
`timescale 1ns / 1ps
// result checker for the integer list parser: predicts each line's results and compares them
module ilp_checker
    import ilp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  in_item_t   s_data,
    input  logic       m_valid,
    input  logic       m_ready,
    input  out_item_t  m_data,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [8:0] cfg_wdata,
    output int         mismatch_count,
    output int         results_owed
);

    typedef enum logic [2:0] {
        AT_START, AFTER_ZERO, IN_DEC, IN_HEX, IN_BIN, AFTER_NUM
    } parse_mode_e;

    logic [2:0]  entry_bytes;
    logic [8:0]  max_entries;
    parse_mode_e mode;
    logic [31:0] acc;
    logic [8:0]  line_count;
    logic [2:0]  line_status;
    out_item_t   parse_results[$];

    initial begin
        mismatch_count = 0;
        results_owed   = 0;
    end

    // 0..15 for a hex digit of either case, 16 otherwise
    function automatic int digit_of(input logic [7:0] c);
        logic [7:0] folded;
        folded = c | 8'h20;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c) - int'(CHAR_ZERO);
        if (folded >= CHAR_LA && folded <= CHAR_LF) return int'(folded) - int'(CHAR_LA) + 10;
        return 16;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        case (c)
            CHAR_SPACE, CHAR_TAB: return 1'b1;
            default:              return 1'b0;
        endcase
    endfunction

    function automatic void clear_line();
        mode        = AT_START;
        acc         = '0;
        line_count  = '0;
        line_status = ST_OK;
    endfunction

    // rejected numbers set the status and leave no result
    function automatic void close_pending_number();
        int          limit;
        logic [63:0] bound;
        limit = (int'(max_entries) < ENTRY_LIMIT) ? int'(max_entries) : ENTRY_LIMIT;
        if (int'(line_count) >= limit) begin
            line_status = ST_TOO_MANY;
            return;
        end
        if (entry_bytes < 3'd4) begin
            bound = 64'd1 << (8 * entry_bytes);
            if (64'(acc) >= bound) begin
                line_status = ST_OUT_OF_RNG;
                return;
            end
        end
        parse_results.push_back({KIND_VALUE, acc, line_count, ST_OK, 1'b0});
        line_count = line_count + 9'd1;
        acc        = '0;
        mode       = AFTER_NUM;
    endfunction

    function automatic void parse_char(input in_item_t req);
        logic [7:0] c;
        int         base;
        int         d;
        c = req.character;
        if (req.line_end) begin
            if (line_status == ST_OK && mode != AT_START && mode != AFTER_NUM)
                close_pending_number();
            parse_results.push_back({KIND_SUMMARY, 32'd0, line_count, line_status, 1'b1});
            clear_line();
            return;
        end
        if (line_status != ST_OK) return;

        if (mode == AT_START) begin
            if (is_space(c)) return;
            acc = '0;
            if (c == CHAR_ZERO) begin
                mode = AFTER_ZERO;
            end else if (c == CHAR_PCT) begin
                mode = IN_BIN;
            end else if (c >= CHAR_ONE && c <= CHAR_NINE) begin
                acc  = 32'(c - CHAR_ZERO);
                mode = IN_DEC;
            end else begin
                line_status = ST_ILLEGAL;
            end
            return;
        end

        if (mode == AFTER_ZERO) begin
            if (c == CHAR_X) begin
                mode = IN_HEX;
                return;
            end
            mode = IN_DEC;
        end

        if (mode == IN_DEC || mode == IN_HEX || mode == IN_BIN) begin
            base = (mode == IN_DEC) ? 10 : ((mode == IN_HEX) ? 16 : 2);
            d    = digit_of(c);
            if (d < base) begin
                acc = acc * 32'(base) + 32'(d);
                return;
            end
            close_pending_number();
            if (line_status != ST_OK) return;
        end

        // between numbers: blanks, then a comma
        if (is_space(c)) begin
            mode = AFTER_NUM;
        end else if (c == CHAR_COMMA) begin
            mode = AT_START;
        end else begin
            line_status = ST_SEP_EXPECT;
        end
    endfunction

    task automatic report(input string what);
        mismatch_count++;
        if (mismatch_count <= 50) $display("%0t mismatch: %s", $time, what);
    endtask

    task automatic compare_result(input out_item_t got);
        out_item_t want;
        if (parse_results.size() == 0) begin
            report($sformatf("unexpected result kind %0d number %0h position %0d status %0d",
                             got.kind, got.number, got.position, got.status));
            return;
        end
        want = parse_results.pop_front();
        if (got.kind != want.kind)
            report($sformatf("kind got %0d want %0d", got.kind, want.kind));
        if (got.number != want.number)
            report($sformatf("number got %0h want %0h", got.number, want.number));
        if (got.position != want.position)
            report($sformatf("position got %0d want %0d", got.position, want.position));
        if (got.status != want.status)
            report($sformatf("status got %0d want %0d", got.status, want.status));
        if (got.last != want.last)
            report($sformatf("last got %0d want %0d", got.last, want.last));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            entry_bytes = 3'd1;
            max_entries = 9'd256;
            clear_line();
            parse_results.delete();
        end else begin
            if (m_valid && m_ready) compare_result(m_data);
            if (cfg_we) begin
                if (cfg_index == CFG_ENTRY_BYTES) entry_bytes = cfg_wdata[2:0];
                else max_entries = cfg_wdata;
            end
            if (s_valid && s_ready) parse_char(s_data);
        end
        results_owed <= parse_results.size();
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// testbench top for the integer list parser: clock, reset, request lines, receiver and verdict
module tb_top;
    import ilp_pkg::*;

    typedef enum int { RADIX_DEC, RADIX_HEX, RADIX_BIN } radix_e;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    in_item_t   s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    out_item_t  m_data;
    logic       cfg_we    = 1'b0;
    logic       cfg_index = CFG_ENTRY_BYTES;
    logic [8:0] cfg_wdata = '0;

    int mismatch_count;
    int results_owed;

    // idle rates in percent; the receiver rate is read at the clock edge, so set it with <=
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // long receiver hold-off: stimulus bumps hold_req, receiver serves it on its own
    int hold_req     = 0;
    int holds_served = 0;
    int hold_left    = 0;

    // entry width in force, steers how long the random numbers get
    logic [2:0] cur_entry_bytes = 3'd1;
    logic [7:0] line_buf[$];

    always #10 aclk = ~aclk;

    integer_list_parser_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    ilp_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    // receiver: random stalls, or a hold-off counted down in hold_left when one is asked for
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != holds_served) begin
            holds_served <= hold_req;
            hold_left    <= 63;
            m_ready      <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // one request: optional idle gap, then hold valid until the edge that takes it
    task automatic send_item(input logic [7:0] c, input logic le);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= {c, le};
        do @(posedge aclk); while (!s_ready);
    endtask

    // line end carries a random character, which the parser must ignore
    task automatic send_line_end();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
        send_line_end();
    endtask

    task automatic send_line_buf();
        foreach (line_buf[i]) send_item(line_buf[i], 1'b0);
        send_line_end();
    endtask

    // wait until every predicted result has left, plus slack;
    // results_owed is registered, so first look at it in the cycle after the last request
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // both registers back to back, write enable held until both are written
    task automatic write_config(input logic [2:0] bytes, input logic [8:0] most);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ENTRY_BYTES;
        cfg_wdata <= 9'(bytes);
        @(posedge aclk);
        cfg_index <= CFG_MAX_ENTRIES;
        cfg_wdata <= most;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cur_entry_bytes = bytes;
    endtask

    // stray byte: half fully random, half the characters that trip the parser
    function automatic logic [7:0] noise_char();
        string tricky;
        tricky = "Xx%,0g \t";
        if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
        return tricky[$urandom_range(0, 7)];
    endfunction

    function automatic void add_blanks(input int most);
        repeat ($urandom_range(0, most))
            line_buf.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
    endfunction

    // random digits of a base; hex letters in either case
    function automatic void add_digits(input int base, input int count);
        int v;
        repeat (count) begin
            v = $urandom_range(0, base - 1);
            if (v < 10) line_buf.push_back(CHAR_ZERO + 8'(v));
            else line_buf.push_back(($urandom_range(0, 1) ? CHAR_UA : CHAR_LA) + 8'(v - 10));
        end
    endfunction

    // lengths mostly near the entry width, so values land on both sides of the bound;
    // one in eight is long enough to wrap the 32-bit accumulator
    function automatic void add_number();
        int     wb;
        int     len;
        logic   long_one;
        radix_e radix;
        wb       = (cur_entry_bytes == 3'd0) ? 1 : ((cur_entry_bytes > 3'd4) ? 4 : cur_entry_bytes);
        long_one = ($urandom_range(0, 7) == 0);
        radix    = radix_e'($urandom_range(0, 2));
        case (radix)
            RADIX_DEC: begin
                len = long_one ? $urandom_range(10, 12) : $urandom_range(1, 2 * wb + 1);
                // a leading zero still reads as decimal
                if ($urandom_range(0, 5) == 0) line_buf.push_back(CHAR_ZERO);
                else line_buf.push_back(CHAR_ONE + 8'($urandom_range(0, 8)));
                add_digits(10, len - 1);
            end
            RADIX_HEX: begin
                line_buf.push_back(CHAR_ZERO);
                line_buf.push_back(CHAR_X);
                // zero digits gives a bare prefix, worth 0
                add_digits(16, long_one ? $urandom_range(9, 10) : $urandom_range(0, 2 * wb));
            end
            default: begin
                line_buf.push_back(CHAR_PCT);
                add_digits(2, long_one ? $urandom_range(33, 36) : $urandom_range(0, 8 * wb));
            end
        endcase
    endfunction

    // mostly well-formed lines with random numbers and blanks; some get one byte
    // overwritten with a stray one, and one in ten is pure noise
    function automatic void build_line();
        int n;
        int i;
        line_buf.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) line_buf.push_back(noise_char());
            return;
        end
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 4);
        add_blanks(1);
        for (i = 0; i < n; i++) begin
            if (i > 0) begin
                add_blanks(2);
                line_buf.push_back(CHAR_COMMA);
                add_blanks(2);
            end
            add_number();
        end
        // trailing comma is still a clean line
        if (n > 0 && $urandom_range(0, 7) == 0) begin
            add_blanks(1);
            line_buf.push_back(CHAR_COMMA);
        end
        add_blanks(1);
        if (line_buf.size() > 0 && $urandom_range(0, 5) == 0)
            line_buf[$urandom_range(0, line_buf.size() - 1)] = noise_char();
    endfunction

    // 257 single-digit numbers: fills the 256-entry limit, the last one is too many
    task automatic send_full_line();
        repeat (257) begin
            send_item(CHAR_ONE, 1'b0);
            send_item(CHAR_COMMA, 1'b0);
        end
        send_line_end();
    endtask

    // one setting: idle, write the registers, ask for a hold-off, optional full line, random lines
    task automatic run_phase(input logic [2:0] bytes, input logic [8:0] most,
                             input int budget, input logic full_line);
        int sent;
        drain();
        write_config(bytes, most);
        // receiver holds off while the sender keeps offering
        hold_req <= hold_req + 1;
        if (full_line) send_full_line();
        sent = 0;
        while (sent < budget) begin
            build_line();
            sent += line_buf.size() + 1;
            send_line_buf();
        end
    endtask

    // hard stop well past the slowest correct run
    initial begin
        #10ms;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // sender idles a quarter of the time, receiver about half
        send_idle_pct = 26;
        recv_idle_pct <= 55;

        // directed lines at reset settings: one byte per entry, 256 entries
        send_line_end();                // empty line
        send_text("0X");                // uppercase x is no prefix: 0 then bad separator
        send_text("\t%,0xff,");         // bare binary prefix, hex, trailing comma
        send_text("256");               // one past the single-byte range
        send_item(8'h00, 1'b0);         // nul is an ordinary, illegal first char
        send_item(8'hff, 1'b0);         // ignored after the error
        send_line_end();

        // no entries allowed at all, no range check
        drain();
        write_config(3'd4, 9'd0);
        send_text("7");

        run_phase(3'd1, 9'd3, 240, 1'b0);
        run_phase(3'd0, 9'd511, 240, 1'b0);

        // now the sender is the one mostly idle
        send_idle_pct = 55;
        recv_idle_pct <= 26;
        run_phase(3'd3, 9'd6, 240, 1'b0);
        run_phase(3'd7, 9'd0, 100, 1'b0);

        // no idling on either side
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        run_phase(3'd4, 9'd256, 240, 1'b1);
        run_phase(3'd2, 9'd1, 240, 1'b0);

        drain();
        if (mismatch_count == 0 && results_owed == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- integer_list_parser_unit.f -----
hw/rtl/ilp_pkg.sv
hw/rtl/integer_list_parser_unit.sv
verif/ilp_checker.sv
verif/tb_top.sv
